[src/cfir_pkg.sv]
// Shared types and constants for the complex FIR convolution block.
package cfir_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int FRAC_BITS     = SAMPLE_BITS - 1;
	localparam int ACC_BITS      = 40;
	localparam int TAP_CNT_BITS  = 7;
	localparam int COEF_IDX_BITS = 6;

	localparam logic [TAP_CNT_BITS-1:0] TAP_CNT_RESET = 7'd49;

	localparam logic MODE_COEF   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef struct packed {
		logic                          mode;
		logic [COEF_IDX_BITS-1:0]      coef_index;
		logic signed [SAMPLE_BITS-1:0] coef_value;
		logic signed [SAMPLE_BITS-1:0] sample_i;
		logic signed [SAMPLE_BITS-1:0] sample_q;
		logic                          frame_last;
	} cfir_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_i;
		logic signed [SAMPLE_BITS-1:0] out_q;
		logic                          out_last;
	} cfir_out_t;

	typedef struct packed {
		logic clr;
		logic en;
		logic lag_ok;
	} cfir_mac_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND
	} cfir_state_t;

endpackage

[src/cfir_mac.sv]
// I/Q multiply-accumulate with a shared coefficient, round-half-up and saturation.
module cfir_mac (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  cfir_pkg::cfir_mac_ctrl_t                ctrl,
	input  logic signed [cfir_pkg::SAMPLE_BITS-1:0] coef,
	input  logic signed [cfir_pkg::SAMPLE_BITS-1:0] x_i,
	input  logic signed [cfir_pkg::SAMPLE_BITS-1:0] x_q,
	output logic                                    busy,
	output logic signed [cfir_pkg::SAMPLE_BITS-1:0] res_i,
	output logic signed [cfir_pkg::SAMPLE_BITS-1:0] res_q
);

	localparam int SB   = cfir_pkg::SAMPLE_BITS;
	localparam int FB   = cfir_pkg::FRAC_BITS;
	localparam int AB   = cfir_pkg::ACC_BITS;
	localparam int QB   = AB - FB;
	localparam logic signed [AB-1:0] RND_HALF = AB'(1 << (FB - 1));
	localparam logic signed [QB-1:0] SAT_HI   = QB'((1 << (SB - 1)) - 1);
	localparam logic signed [QB-1:0] SAT_LO   = -QB'(1 << (SB - 1));

	function automatic logic signed [SB-1:0] round_sat(input logic signed [AB-1:0] acc);
		logic signed [AB-1:0] r;
		logic signed [QB-1:0] q;
		r = acc + RND_HALF;
		q = $signed(r[AB-1:FB]);
		if (q > SAT_HI) begin
			q = SAT_HI;
		end else if (q < SAT_LO) begin
			q = SAT_LO;
		end
		return q[SB-1:0];
	endfunction

	logic signed [2*SB-1:0] prod_i_s2;
	logic signed [2*SB-1:0] prod_q_s2;
	logic                   en_s2;
	logic signed [AB-1:0]   acc_i_q;
	logic signed [AB-1:0]   acc_q_q;
	logic signed [SB-1:0]   xm_i;
	logic signed [SB-1:0]   xm_q;

	// lags older than the frame start read as zero
	assign xm_i = ctrl.lag_ok ? x_i : '0;
	assign xm_q = ctrl.lag_ok ? x_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s2 <= 1'b0;
		end else begin
			en_s2 <= ctrl.en;
		end
	end

	always_ff @(posedge clk) begin
		prod_i_s2 <= coef * xm_i;
		prod_q_s2 <= coef * xm_q;
		if (ctrl.clr) begin
			acc_i_q <= '0;
			acc_q_q <= '0;
		end else if (en_s2) begin
			acc_i_q <= acc_i_q + AB'(prod_i_s2);
			acc_q_q <= acc_q_q + AB'(prod_q_s2);
		end
	end

	assign busy  = en_s2;
	assign res_i = round_sat(acc_i_q);
	assign res_q = round_sat(acc_q_q);

endmodule

[src/complex_fir_full_convolution.sv]
// Complex FIR filter computing the full linear convolution of each I/Q frame.
// Words with mode 0 load one coefficient; words with mode 1
// push one I/Q sample and yield one result. A sample flagged frame_last is
// followed by taps-1 tail results, where taps is tap_count clamped to
// 1..MAX_TAPS; after that the delay line is empty again. Every result walks
// the taps through one multiply-accumulate per rail fed from the delay-line
// and coefficient memories. The block takes no word while a result is in
// progress; the output register lets the next result be computed while
// the previous one waits.
module complex_fir_full_convolution #(
	parameter int MAX_TAPS = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   req_valid,
	output logic                                   req_ready,
	input  cfir_pkg::cfir_in_t                     req_data,
	output logic                                   rsp_valid,
	input  logic                                   rsp_ready,
	output cfir_pkg::cfir_out_t                    rsp_data,
	input  logic                                   cfg_we,
	input  logic [cfir_pkg::TAP_CNT_BITS-1:0]      cfg_wdata
);

	localparam int SB = cfir_pkg::SAMPLE_BITS;
	localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CW = $clog2(MAX_TAPS + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TAPS - 1);
	localparam logic [CW-1:0] TAPS_MAX  = CW'(MAX_TAPS);

	cfir_pkg::cfir_state_t state_q, state_d;

	logic [cfir_pkg::TAP_CNT_BITS-1:0] tap_count_q;
	logic signed [SB-1:0]              cur_i_q;
	logic signed [SB-1:0]              cur_q_q;
	logic                              last_q;
	logic [CW-1:0]                     rem_q;
	logic [CW-1:0]                     taps_q;
	logic [CW-1:0]                     k_q;
	logic [CW-1:0]                     fill_q;
	logic [AW-1:0]                     wslot_q;
	logic [AW-1:0]                     rptr_q;
	logic                              rd_v_s1;
	logic                              lag_ok_s1;
	logic [2*SB-1:0]                   hist_rd_s1;
	logic signed [SB-1:0]              coef_rd_s1;
	logic                              rsp_valid_q;
	cfir_pkg::cfir_out_t               rsp_q;

	logic [2*SB-1:0]      hist_mem [MAX_TAPS];
	logic signed [SB-1:0] coef_mem [MAX_TAPS];

	logic                     accept;
	logic                     coef_wr;
	logic                     sample_acc;
	logic                     push;
	logic                     issue;
	logic                     load_out;
	logic                     rsp_free;
	logic                     mac_busy;
	logic [8:0]               tc_ext;
	logic [8:0]               cidx_ext;
	logic [CW-1:0]            taps_c;
	logic signed [SB-1:0]     res_i;
	logic signed [SB-1:0]     res_q;
	cfir_pkg::cfir_mac_ctrl_t mac_ctrl;

	assign tc_ext   = 9'(tap_count_q);
	assign cidx_ext = 9'(req_data.coef_index);

	always_comb begin
		if (tc_ext == 9'd0) begin
			taps_c = CW'(1);
		end else if (tc_ext > 9'(MAX_TAPS)) begin
			taps_c = TAPS_MAX;
		end else begin
			taps_c = tc_ext[CW-1:0];
		end
	end

	assign rsp_free   = !rsp_valid_q || rsp_ready;
	assign accept     = req_valid && req_ready;
	assign coef_wr    = accept && (req_data.mode == cfir_pkg::MODE_COEF)
		&& (cidx_ext < 9'(MAX_TAPS));
	assign sample_acc = accept && (req_data.mode == cfir_pkg::MODE_SAMPLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			cfir_pkg::ST_IDLE: begin
				if (sample_acc) begin
					state_d = cfir_pkg::ST_PUSH;
				end
			end
			cfir_pkg::ST_PUSH: state_d = cfir_pkg::ST_MAC;
			cfir_pkg::ST_MAC: begin
				if (k_q == taps_q - CW'(1)) begin
					state_d = cfir_pkg::ST_DRAIN;
				end
			end
			cfir_pkg::ST_DRAIN: begin
				if (!rd_v_s1 && !mac_busy) begin
					state_d = cfir_pkg::ST_ROUND;
				end
			end
			cfir_pkg::ST_ROUND: begin
				if (rsp_free) begin
					state_d = (rem_q != '0) ? cfir_pkg::ST_PUSH : cfir_pkg::ST_IDLE;
				end
			end
			default: state_d = cfir_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		push      = 1'b0;
		issue     = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			cfir_pkg::ST_IDLE:  req_ready = 1'b1;
			cfir_pkg::ST_PUSH:  push      = 1'b1;
			cfir_pkg::ST_MAC:   issue     = 1'b1;
			cfir_pkg::ST_DRAIN: ;
			cfir_pkg::ST_ROUND: load_out  = rsp_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cfir_pkg::ST_IDLE;
			tap_count_q <= cfir_pkg::TAP_CNT_RESET;
			wslot_q     <= '0;
			fill_q      <= '0;
			rem_q       <= '0;
			last_q      <= 1'b0;
			rd_v_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (cfg_we) begin
				tap_count_q <= cfg_wdata;
			end
			if (sample_acc) begin
				last_q <= req_data.frame_last;
				rem_q  <= req_data.frame_last ? taps_c - CW'(1) : '0;
			end
			if (push) begin
				wslot_q <= (wslot_q == LAST_SLOT) ? '0 : wslot_q + AW'(1);
				if (fill_q != TAPS_MAX) begin
					fill_q <= fill_q + CW'(1);
				end
			end
			if (load_out) begin
				if (rem_q != '0) begin
					rem_q <= rem_q - CW'(1);
				end else if (last_q) begin
					wslot_q <= '0;
					fill_q  <= '0;
				end
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc) begin
			cur_i_q <= req_data.sample_i;
			cur_q_q <= req_data.sample_q;
			taps_q  <= taps_c;
		end
		if (push) begin
			rptr_q <= wslot_q;
			k_q    <= '0;
		end
		if (issue) begin
			rptr_q <= (rptr_q == '0) ? LAST_SLOT : rptr_q - AW'(1);
			k_q    <= k_q + CW'(1);
		end
		lag_ok_s1 <= k_q < fill_q;
		if (load_out) begin
			rsp_q.out_i    <= res_i;
			rsp_q.out_q    <= res_q;
			rsp_q.out_last <= last_q && (rem_q == '0);
			if (rem_q != '0) begin
				cur_i_q <= '0;
				cur_q_q <= '0;
			end
		end
	end

	// delay line: I in the upper half, Q in the lower half
	always_ff @(posedge clk) begin
		if (push) begin
			hist_mem[wslot_q] <= {cur_i_q, cur_q_q};
		end
		hist_rd_s1 <= hist_mem[rptr_q];
	end

	always_ff @(posedge clk) begin
		if (coef_wr) begin
			coef_mem[cidx_ext[AW-1:0]] <= req_data.coef_value;
		end
		coef_rd_s1 <= coef_mem[k_q[AW-1:0]];
	end

	assign mac_ctrl.clr    = push;
	assign mac_ctrl.en     = rd_v_s1;
	assign mac_ctrl.lag_ok = lag_ok_s1;

	cfir_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.coef   (coef_rd_s1),
		.x_i    ($signed(hist_rd_s1[2*SB-1:SB])),
		.x_q    ($signed(hist_rd_s1[SB-1:0])),
		.busy   (mac_busy),
		.res_i  (res_i),
		.res_q  (res_q)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

[tb/sv/cfir_conv_checker.sv]
`timescale 1ns / 100ps
// Checker for the complex FIR convolution block: predicts every result word and compares it.
module cfir_conv_checker #(
	parameter int MAX_TAPS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	input  logic                                req_ready,
	input  cfir_pkg::cfir_in_t                  req_data,
	input  logic                                rsp_valid,
	input  logic                                rsp_ready,
	input  cfir_pkg::cfir_out_t                 rsp_data,
	input  logic                                cfg_we,
	input  logic [cfir_pkg::TAP_CNT_BITS-1:0]   cfg_wdata,
	output int                                  fail_count,
	output int                                  open_count,
	output int                                  result_count
);
	import cfir_pkg::*;

	logic signed [SAMPLE_BITS-1:0] hist_i [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] hist_q [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] coef [MAX_TAPS];
	logic [TAP_CNT_BITS-1:0]       taps_reg;
	int                            slot;
	int                            errors;
	int                            got;
	cfir_out_t                     filtered_q [$];

	function automatic int taps_used();
		int n;
		begin
			n = taps_reg;
			if (n < 1)
				n = 1;
			if (n > MAX_TAPS)
				n = MAX_TAPS;
			return n;
		end
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] round_saturate(input longint acc);
		longint r;
		longint hi;
		longint lo;
		begin
			hi = (longint'(1) <<< FRAC_BITS) - 1;
			lo = -(longint'(1) <<< FRAC_BITS);
			r = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			if (r > hi)
				r = hi;
			if (r < lo)
				r = lo;
			return SAMPLE_BITS'(r);
		end
	endfunction

	task automatic filter_step(input logic signed [SAMPLE_BITS-1:0] xi,
	                           input logic signed [SAMPLE_BITS-1:0] xq, input logic flag);
		longint    acc_i;
		longint    acc_q;
		int        k;
		int        p;
		int        n;
		cfir_out_t r;
		begin
			n = taps_used();
			hist_i[slot] = xi;
			hist_q[slot] = xq;
			acc_i = 0;
			acc_q = 0;
			for (k = 0; k < n; k++) begin
				p = (slot + MAX_TAPS - k) % MAX_TAPS;
				acc_i += longint'(coef[k]) * longint'(hist_i[p]);
				acc_q += longint'(coef[k]) * longint'(hist_q[p]);
			end
			slot = (slot + 1) % MAX_TAPS;
			r.out_i = round_saturate(acc_i);
			r.out_q = round_saturate(acc_q);
			r.out_last = flag;
			filtered_q.push_back(r);
		end
	endtask

	task automatic clear_history();
		int k;
		begin
			for (k = 0; k < MAX_TAPS; k++) begin
				hist_i[k] = '0;
				hist_q[k] = '0;
			end
			slot = 0;
		end
	endtask

	task automatic accept_word(input cfir_in_t w);
		int n;
		int t;
		begin
			if (w.mode == MODE_COEF) begin
				if (w.coef_index < MAX_TAPS)
					coef[w.coef_index] = w.coef_value;
			end else begin
				n = taps_used();
				filter_step(w.sample_i, w.sample_q, w.frame_last && n == 1);
				if (w.frame_last) begin
					// tail: zeros pushed through until the last tap has left
					for (t = 1; t < n; t++)
						filter_step('0, '0, t == n - 1);
					clear_history();
				end
			end
		end
	endtask

	task automatic check_result(input cfir_out_t act);
		cfir_out_t ex;
		begin
			if (filtered_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result word with nothing expected: i=%0d q=%0d last=%0b",
						$signed(act.out_i), $signed(act.out_q), act.out_last);
			end else begin
				ex = filtered_q.pop_front();
				if (act.out_i !== ex.out_i || act.out_q !== ex.out_q ||
				    act.out_last !== ex.out_last) begin
					errors++;
					if (errors <= 10)
						$display("result %0d mismatch: expected i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
							got, $signed(ex.out_i), $signed(ex.out_q), ex.out_last,
							$signed(act.out_i), $signed(act.out_q), act.out_last);
				end
			end
			got++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_history();
			for (int k = 0; k < MAX_TAPS; k++)
				coef[k] = '0;
			taps_reg = TAP_CNT_RESET;
			filtered_q.delete();
			errors = 0;
			got = 0;
			fail_count <= 0;
			open_count <= 0;
			result_count <= 0;
		end else begin
			if (rsp_valid && rsp_ready)
				check_result(rsp_data);
			if (cfg_we)
				taps_reg = cfg_wdata;
			if (req_valid && req_ready)
				accept_word(req_data);
			fail_count <= errors;
			open_count <= filtered_q.size();
			result_count <= got;
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Top of the complex FIR convolution testbench: clock, reset, stimulus and verdict.
module testbench;
	import cfir_pkg::*;

	localparam int MAX_TAPS = 64;
	localparam int LIMIT = 5_000_000;
	localparam int WORDS_PER_PHASE = 11;
	localparam int PHASE_TAPS [12] = '{2, 5, 1, 64, 3, 127, 0, 17, 8, 33, 4, 49};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    req_valid = 1'b0;
	logic                    req_ready;
	cfir_in_t                req_data = '0;
	logic                    rsp_valid;
	logic                    rsp_ready = 1'b0;
	cfir_out_t               rsp_data;
	logic                    cfg_we = 1'b0;
	logic [TAP_CNT_BITS-1:0] cfg_wdata = TAP_CNT_RESET;

	int fail_count;
	int open_count;
	int result_count;
	int cycles = 0;
	bit calm = 1'b0;
	int n_samples = 0;
	int n_coefs = 0;
	int n_frames = 0;
	int n_settings = 0;

	complex_fir_full_convolution #(.MAX_TAPS(MAX_TAPS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	cfir_conv_checker #(.MAX_TAPS(MAX_TAPS)) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_data     (req_data),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp_data     (rsp_data),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.open_count   (open_count),
		.result_count (result_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ready <= calm || ($urandom_range(0, 99) >= 29);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [SAMPLE_BITS-1:0] rand16();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_word(input cfir_in_t w);
		begin
			if (!calm && $urandom_range(0, 99) < 29) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while ($urandom_range(0, 99) < 29)
					@(posedge clk);
			end
			req_valid <= 1'b1;
			req_data <= w;
			@(posedge clk);
			while (!req_ready)
				@(posedge clk);
		end
	endtask

	task automatic coef_word(input int idx, input logic [SAMPLE_BITS-1:0] val);
		cfir_in_t w;
		begin
			w.mode = MODE_COEF;
			w.coef_index = COEF_IDX_BITS'(idx);
			w.coef_value = val;
			w.sample_i = 16'($urandom);
			w.sample_q = 16'($urandom);
			w.frame_last = 1'($urandom);
			send_word(w);
			n_coefs++;
		end
	endtask

	task automatic sample_word(input logic [SAMPLE_BITS-1:0] si, input logic [SAMPLE_BITS-1:0] sq,
	                           input logic last);
		cfir_in_t w;
		begin
			w.mode = MODE_SAMPLE;
			w.coef_index = COEF_IDX_BITS'($urandom);
			w.coef_value = 16'($urandom);
			w.sample_i = si;
			w.sample_q = sq;
			w.frame_last = last;
			send_word(w);
			n_samples++;
			if (last)
				n_frames++;
		end
	endtask

	// hold off until every expected word is back, then let the block settle
	task automatic drain();
		begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while (open_count != 0);
			repeat (2 * MAX_TAPS + 16) @(posedge clk);
		end
	endtask

	task automatic set_taps(input int v);
		begin
			drain();
			cfg_we <= 1'b1;
			cfg_wdata <= TAP_CNT_BITS'(v);
			@(posedge clk);
			cfg_we <= 1'b0;
			n_settings++;
		end
	endtask

	initial begin
		int ph;
		int j;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full coefficient load before any sample
		for (j = 0; j < MAX_TAPS; j++)
			coef_word(j, j == 0 ? 16'h8000 : rand16());

		// reset tap count
		sample_word(16'h7fff, 16'h8000, 1'b0);
		sample_word(16'h8000, 16'h7fff, 1'b0);
		sample_word(rand16(), rand16(), 1'b1);

		// single tap: full-scale product, mid-frame coefficient update
		set_taps(1);
		sample_word(16'h8000, 16'h8000, 1'b0);
		sample_word(16'h7fff, 16'h8000, 1'b0);
		coef_word(0, 16'h7fff);
		coef_word(63, 16'h7fff);
		sample_word(16'h8000, 16'h7fff, 1'b0);
		sample_word(16'h0000, 16'h0000, 1'b1);

		set_taps(0);
		sample_word(rand16(), rand16(), 1'b0);
		sample_word(rand16(), rand16(), 1'b1);

		set_taps(127);
		sample_word(16'h8000, 16'h8000, 1'b0);
		sample_word(rand16(), rand16(), 1'b1);

		set_taps(64);
		coef_word(0, 16'h8000);
		sample_word(16'h8000, 16'h7fff, 1'b1);

		for (ph = 0; ph < 12; ph++) begin
			set_taps(PHASE_TAPS[ph]);
			calm = (ph == 3 || ph == 4);
			for (j = 0; j < WORDS_PER_PHASE; j++) begin
				if ($urandom_range(0, 99) < 12)
					coef_word($urandom_range(0, MAX_TAPS - 1), rand16());
				else
					sample_word(rand16(), rand16(),
						$urandom_range(0, 5) == 0 || j == WORDS_PER_PHASE - 1);
			end
		end
		calm = 1'b0;
		drain();

		$display("sent %0d sample words in %0d frames and %0d coefficient words",
			n_samples, n_frames, n_coefs);
		$display("over %0d tap settings; %0d result words checked", n_settings, result_count);
		if (fail_count == 0 && open_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[files.f]
src/cfir_pkg.sv
src/cfir_mac.sv
src/complex_fir_full_convolution.sv
tb/sv/cfir_conv_checker.sv
tb/sv/testbench.sv
